/* src/dbs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dbs_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_BITS  = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 80;

  typedef enum logic [2:0] {
    CMD_ADD_FRONT    = 3'd0,
    CMD_ADD_BACK     = 3'd1,
    CMD_REMOVE_FRONT = 3'd2,
    CMD_REMOVE_BACK  = 3'd3,
    CMD_CONTAINS     = 3'd4,
    CMD_REMOVE_VALUE = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan_step;
    logic shift_step;
    logic fetch_front;
    logic fetch_back;
    logic load;
  } ctrl_t;

  typedef struct packed {
    logic search;
    logic remove_value;
    logic hit;
    logic scan_miss;
    logic shift_done;
    logic out_free;
  } stat_t;

  function automatic logic [IDX_W-1:0] slot_of(logic [IDX_W-1:0] head,
                                               logic [CNT_W-1:0] pos);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, pos};
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* src/dbs_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module dbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/dbs_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module dbs_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire dbs_pkg::ctrl_t                   ctrl,
  output dbs_pkg::stat_t                        stat,
  input  wire logic [dbs_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [dbs_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  localparam int IDX_W = dbs_pkg::IDX_W;
  localparam int CNT_W = dbs_pkg::CNT_W;
  localparam int VB    = dbs_pkg::VALUE_BITS;

  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;
  dbs_pkg::cmd_t    cmd;
  logic [VB-1:0]    value;
  logic             found;
  dbs_pkg::err_t    err;
  logic [CNT_W-1:0] scan_i;
  logic             pend;
  logic [CNT_W-1:0] pend_pos;
  logic [VB-1:0]    front;

  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [VB-1:0]    wdata;
  logic             re;
  logic [IDX_W-1:0] raddr;
  logic [VB-1:0]    rdata;

  logic             full;
  logic             empty;
  logic             is_add;
  logic             is_end_remove;
  logic             more;
  logic [IDX_W-1:0] head_dec;

  dbs_ram #(
    .WIDTH(VB),
    .DEPTH(dbs_pkg::DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign full     = (count == CNT_W'(dbs_pkg::DEPTH));
  assign empty    = (count == '0);
  assign more     = (scan_i < count);
  assign head_dec = (head == '0) ? IDX_W'(dbs_pkg::DEPTH - 1) : head - 1'b1;
  assign is_add   = (cmd == dbs_pkg::CMD_ADD_FRONT) || (cmd == dbs_pkg::CMD_ADD_BACK);
  assign is_end_remove = (cmd == dbs_pkg::CMD_REMOVE_FRONT) ||
                         (cmd == dbs_pkg::CMD_REMOVE_BACK);

  always_comb begin
    stat.search       = (cmd == dbs_pkg::CMD_CONTAINS) || (cmd == dbs_pkg::CMD_REMOVE_VALUE);
    stat.remove_value = (cmd == dbs_pkg::CMD_REMOVE_VALUE);
    stat.hit          = pend && (rdata == value);
    stat.scan_miss    = !(pend && (rdata == value)) && !more;
    stat.shift_done   = !pend && !more;
    stat.out_free     = !m_tvalid || m_tready;
  end

  always_comb begin
    we    = 1'b0;
    waddr = dbs_pkg::slot_of(head, count);
    wdata = value;
    if (ctrl.exec && is_add && !full) begin
      we = 1'b1;
      if (cmd == dbs_pkg::CMD_ADD_FRONT) begin
        waddr = head_dec;
      end
    end else if (ctrl.shift_step && pend) begin
      we    = 1'b1;
      waddr = dbs_pkg::slot_of(head, pend_pos);
      wdata = rdata;
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = dbs_pkg::slot_of(head, scan_i);
    if (ctrl.scan_step) begin
      re = !stat.hit && more;
    end else if (ctrl.shift_step) begin
      re = more;
    end else if (ctrl.fetch_front) begin
      re    = 1'b1;
      raddr = head;
    end else if (ctrl.fetch_back) begin
      re    = 1'b1;
      raddr = dbs_pkg::slot_of(head, count - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (ctrl.capture) begin
        cmd   <= dbs_pkg::cmd_t'(s_tdata[2:0]);
        value <= s_tdata[3 +: VB];
        found <= 1'b0;
        err   <= dbs_pkg::ERR_OK;
      end

      if (ctrl.exec) begin
        scan_i <= '0;
        pend   <= 1'b0;
        if (is_add) begin
          if (full) begin
            err <= dbs_pkg::ERR_FULL;
          end else begin
            count <= count + 1'b1;
            if (cmd == dbs_pkg::CMD_ADD_FRONT) begin
              head <= head_dec;
            end
          end
        end else if (is_end_remove) begin
          if (empty) begin
            err <= dbs_pkg::ERR_EMPTY;
          end else begin
            count <= count - 1'b1;
            if (cmd == dbs_pkg::CMD_REMOVE_FRONT) begin
              head <= dbs_pkg::slot_of(head, CNT_W'(1));
            end
          end
        end
      end

      if (ctrl.scan_step) begin
        if (stat.hit) begin
          found  <= 1'b1;
          scan_i <= pend_pos + 1'b1;
          pend   <= 1'b0;
        end else if (more) begin
          pend     <= 1'b1;
          pend_pos <= scan_i;
          scan_i   <= scan_i + 1'b1;
        end
      end

      if (ctrl.shift_step) begin
        if (more) begin
          pend     <= 1'b1;
          pend_pos <= scan_i - 1'b1;
          scan_i   <= scan_i + 1'b1;
        end else begin
          pend <= 1'b0;
          if (!pend) begin
            count <= count - 1'b1;
          end
        end
      end

      if (ctrl.fetch_back) begin
        front <= rdata;
      end

      if (ctrl.load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {7'b0, err, found, empty, count,
                     empty ? VB'(0) : rdata,
                     empty ? VB'(0) : front};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* src/dbs_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module dbs_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire dbs_pkg::stat_t stat,
  output dbs_pkg::ctrl_t      ctrl
);

  typedef enum logic [6:0] {
    ST_IDLE        = 7'b0000001,
    ST_EXEC        = 7'b0000010,
    ST_SCAN        = 7'b0000100,
    ST_SHIFT       = 7'b0001000,
    ST_FETCH_FRONT = 7'b0010000,
    ST_FETCH_BACK  = 7'b0100000,
    ST_LOAD        = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    ctrl       = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          ctrl.capture = 1'b1;
          state_next   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctrl.exec  = 1'b1;
        state_next = stat.search ? ST_SCAN : ST_FETCH_FRONT;
      end
      ST_SCAN: begin
        ctrl.scan_step = 1'b1;
        if (stat.hit) begin
          state_next = stat.remove_value ? ST_SHIFT : ST_FETCH_FRONT;
        end else if (stat.scan_miss) begin
          state_next = ST_FETCH_FRONT;
        end
      end
      ST_SHIFT: begin
        ctrl.shift_step = 1'b1;
        if (stat.shift_done) begin
          state_next = ST_FETCH_FRONT;
        end
      end
      ST_FETCH_FRONT: begin
        ctrl.fetch_front = 1'b1;
        state_next       = ST_FETCH_BACK;
      end
      ST_FETCH_BACK: begin
        ctrl.fetch_back = 1'b1;
        state_next      = ST_LOAD;
      end
      ST_LOAD: begin
        if (stat.out_free) begin
          ctrl.load  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* src/deque_bag_store_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bounded double-ended queue of 16 signed 32-bit words held in a circular
// single-port-write, registered-read RAM. Each request carries a command and a
// value and yields exactly one result holding the front and back values (zero
// when empty), the count, an empty flag, a found flag and an error code. An add
// to a full store or an end remove on an empty one is refused with an error and
// changes nothing. A contains or remove-value request scans the RAM one entry
// per cycle. A remove by value that matches then closes the gap by copying each
// later entry one place forward through the same RAM port pair, one entry per
// cycle; the longest requests are removes by value that match any entry but the
// back of a full store. One request is in work at a time; a finished result
// waits in the output register while the next request is accepted.

module deque_bag_store_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // s_tdata from bit 0: cmd[2:0], value[34:3], zero fill.
  input  wire logic [dbs_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // m_tdata from bit 0: front_value[31:0], back_value[63:32], item_count[68:64],
  // is_empty[69], found[70], error_code[72:71], zero fill.
  output logic      [dbs_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  dbs_pkg::ctrl_t ctrl;
  dbs_pkg::stat_t stat;

  dbs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .stat    (stat),
    .ctrl    (ctrl)
  );

  dbs_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .stat    (stat),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import dbs_pkg::*;

  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam int GAP_MAX      = 18;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1500;
  localparam int CHUNK_ITEMS  = 300;
  localparam int SWING_ITEMS  = 40;

  typedef struct packed {
    logic [31:0]      front;
    logic [31:0]      back;
    logic [CNT_W-1:0] count;
    logic             empty;
    logic             found;
    err_t             err;
  } deque_status_t;

  class deque_scoreboard;
    logic [VALUE_BITS-1:0] slots [DEPTH];
    logic [IDX_W-1:0]      head;
    logic [CNT_W-1:0]      count;
    deque_status_t         status_q[$];
    int mismatches;
    int requests;
    int results;
    int full_refusals;
    int empty_refusals;
    int value_hits;
    int value_removals;
    int peak_fill;

    function new();
      head = '0;
      count = '0;
      mismatches = 0;
      requests = 0;
      results = 0;
      full_refusals = 0;
      empty_refusals = 0;
      value_hits = 0;
      value_removals = 0;
      peak_fill = 0;
    endfunction

    function int slot(int pos);
      return (int'(head) + pos) % DEPTH;
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    function void note_request(logic [2:0] cmd, logic [31:0] value);
      deque_status_t st;
      logic hit;
      int match_pos;
      hit = 1'b0;
      match_pos = 0;
      st.err = ERR_OK;
      requests++;
      case (cmd)
        CMD_ADD_FRONT, CMD_ADD_BACK: begin
          if (count == DEPTH) begin
            st.err = ERR_FULL;
            full_refusals++;
          end else if (cmd == CMD_ADD_FRONT) begin
            head = (head == 0) ? IDX_W'(DEPTH - 1) : head - 1'b1;
            slots[head] = value;
            count++;
          end else begin
            slots[slot(count)] = value;
            count++;
          end
        end
        CMD_REMOVE_FRONT, CMD_REMOVE_BACK: begin
          if (count == 0) begin
            st.err = ERR_EMPTY;
            empty_refusals++;
          end else begin
            if (cmd == CMD_REMOVE_FRONT) head = IDX_W'(slot(1));
            count--;
          end
        end
        CMD_CONTAINS, CMD_REMOVE_VALUE: begin
          for (int i = 0; i < count; i++) begin
            if (!hit && slots[slot(i)] == value) begin
              hit = 1'b1;
              match_pos = i;
            end
          end
          if (hit) value_hits++;
          if (hit && cmd == CMD_REMOVE_VALUE) begin
            for (int k = match_pos; k + 1 < count; k++) begin
              slots[slot(k)] = slots[slot(k + 1)];
            end
            count--;
            value_removals++;
          end
        end
        default: ;
      endcase
      if (count > peak_fill) peak_fill = count;
      st.front = (count == 0) ? '0 : slots[slot(0)];
      st.back  = (count == 0) ? '0 : slots[slot(count - 1)];
      st.count = count;
      st.empty = (count == 0);
      st.found = hit;
      status_q.push_back(st);
    endfunction

    function void compare_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("MISMATCH result %0d %s: expected %h, got %h",
                   results, field, exp_v, act_v);
        end
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata);
      deque_status_t exp_st;
      results++;
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("MISMATCH result %0d arrived with no request waiting: %h", results, tdata);
        end
      end else begin
        exp_st = status_q.pop_front();
        compare_field("front_value", exp_st.front, tdata[31:0]);
        compare_field("back_value", exp_st.back, tdata[63:32]);
        compare_field("item_count", 32'(exp_st.count), 32'(tdata[68:64]));
        compare_field("is_empty", 32'(exp_st.empty), 32'(tdata[69]));
        compare_field("found", 32'(exp_st.found), 32'(tdata[70]));
        compare_field("error_code", 32'(exp_st.err), 32'(tdata[72:71]));
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  deque_scoreboard sb;
  logic [31:0] value_pool [8];
  bit fast_phase;
  bit hold_requested;
  int idle_cycles;

  deque_bag_store_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_request(s_tdata[2:0], s_tdata[34:3]);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("Timeout: no request or result moved for %0d cycles.", STALL_LIMIT);
        $display("deque_bag_store_top verification failed");
        $finish;
      end
    end
  end

  task automatic send_request(logic [2:0] cmd, logic [31:0] value);
    int gap;
    gap = fast_phase ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, value, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_search_value();
    if (sb.count > 0 && $urandom_range(0, 9) < 6) begin
      return sb.slots[sb.slot($urandom_range(0, sb.count - 1))];
    end
    return pick_value();
  endfunction

  function automatic logic [2:0] pick_cmd(bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 25) return CMD_ADD_FRONT;
      if (r < 50) return CMD_ADD_BACK;
      if (r < 60) return CMD_REMOVE_FRONT;
      if (r < 68) return CMD_REMOVE_BACK;
      if (r < 80) return CMD_CONTAINS;
      if (r < 95) return CMD_REMOVE_VALUE;
    end else begin
      if (r < 10) return CMD_ADD_FRONT;
      if (r < 18) return CMD_ADD_BACK;
      if (r < 40) return CMD_REMOVE_FRONT;
      if (r < 62) return CMD_REMOVE_BACK;
      if (r < 75) return CMD_CONTAINS;
      if (r < 95) return CMD_REMOVE_VALUE;
    end
    return r[0] ? CMD_SPARE_6 : CMD_SPARE_7;
  endfunction

  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_requested) begin
        hold_requested = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = fast_phase ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin
    logic [2:0] cmd;
    bit filling;
    sb = new();
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h7FFF_FFFF;
    value_pool[3] = 32'h8000_0000;
    value_pool[4] = 32'h0000_0005;
    value_pool[5] = 32'h0000_0011;
    value_pool[6] = 32'h00FF_00FF;
    value_pool[7] = 32'hDEAD_BEEF;
    fast_phase = 1'b0;
    hold_requested = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty store: end removes are refused, searches and spare codes do nothing.
    send_request(CMD_REMOVE_FRONT, 32'h0);
    send_request(CMD_REMOVE_BACK, 32'h1234_5678);
    send_request(CMD_CONTAINS, 32'h0);
    send_request(CMD_REMOVE_VALUE, 32'h0);
    send_request(CMD_SPARE_6, 32'hFFFF_FFFF);
    send_request(CMD_SPARE_7, 32'h5555_5555);
    // Fill to capacity from both ends with repeated values, then overfill and run searches and removes.
    for (int i = 0; i < DEPTH; i++) begin
      send_request(i[0] ? CMD_ADD_BACK : CMD_ADD_FRONT, value_pool[i % 8]);
    end
    send_request(CMD_ADD_FRONT, 32'h1);
    send_request(CMD_ADD_BACK, 32'h2);
    send_request(CMD_CONTAINS, 32'h8000_0000);
    send_request(CMD_REMOVE_VALUE, 32'hDEAD_BEEF);
    send_request(CMD_REMOVE_VALUE, 32'h0BAD_0BAD);
    send_request(CMD_REMOVE_FRONT, 32'h0);
    send_request(CMD_REMOVE_BACK, 32'h0);

    filling = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % CHUNK_ITEMS == 0) begin
        fast_phase = ((n / CHUNK_ITEMS) % 2) == 1;
        if (fast_phase) hold_requested = 1'b1;
      end
      if (n % SWING_ITEMS == 0) filling = !filling;
      cmd = pick_cmd(filling);
      if (cmd == CMD_CONTAINS || cmd == CMD_REMOVE_VALUE) begin
        send_request(cmd, pick_search_value());
      end else begin
        send_request(cmd, pick_value());
      end
    end
    s_tvalid <= 1'b0;
    fast_phase = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests and %0d results, peak fill %0d of %0d.",
             sb.requests, sb.results, sb.peak_fill, DEPTH);
    $display("Refused adds %0d, refused removes %0d, value hits %0d, removals by value %0d.",
             sb.full_refusals, sb.empty_refusals, sb.value_hits, sb.value_removals);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("deque_bag_store_top verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing.", sb.mismatches, sb.pending());
      $display("deque_bag_store_top verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/dbs_pkg.sv
src/dbs_ram.sv
src/dbs_datapath.sv
src/dbs_ctrl.sv
src/deque_bag_store_top.sv
tb/tb_top.sv
